[design/assert_macros.svh]
// Assertion helpers shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define KWQ_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every edge, reset included.
`define KWQ_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

[design/kwq_pkg.sv]
`timescale 1ns / 1ps
package kwq_pkg;

   localparam int NUM_THREADS = 16;
   localparam int NUM_QUEUES  = 8;

   localparam int ThreadWidth = 4;
   localparam int QueueWidth  = 3;
   localparam int KeyWidth    = 64;
   localparam int CountWidth  = 5;

   localparam logic [2:0] CMD_SLEEP     = 3'd0;
   localparam logic [2:0] CMD_WAKE_ONE  = 3'd1;
   localparam logic [2:0] CMD_WAKE_ALL  = 3'd2;
   localparam logic [2:0] CMD_WAKE_KEY  = 3'd3;
   localparam logic [2:0] CMD_CANCEL    = 3'd4;
   localparam logic [2:0] CMD_INTERRUPT = 3'd5;

   localparam logic [1:0] STATUS_DONE    = 2'd0;
   localparam logic [1:0] STATUS_REFUSED = 2'd1;
   localparam logic [1:0] STATUS_INTR    = 2'd2;
   localparam logic [1:0] STATUS_NONE    = 2'd3;

   // one waiting thread, held by a cell
   typedef struct packed {
      logic                   valid;
      logic [ThreadWidth-1:0] thread;
      logic [QueueWidth-1:0]  queue;
      logic [KeyWidth-1:0]    key;
      logic                   intr;
   } cell_data_type;

   // command broadcast to every cell
   typedef struct packed {
      logic                   by_thread;
      logic                   need_intr;
      logic                   keyed;
      logic [ThreadWidth-1:0] thread;
      logic [QueueWidth-1:0]  queue;
      logic [KeyWidth-1:0]    key;
      logic                   intr;
      logic                   kill_en;
      logic                   load_en;
   } bcast_type;

   // status rippling from older cells to younger cells
   typedef struct packed {
      logic                   shift;
      logic                   found;
      logic                   more;
      logic                   prev_valid;
      logic [ThreadWidth-1:0] thread;
   } chain_type;

endpackage

[design/keyed_wait_queue_table_core.sv]
`timescale 1ns / 1ps
// Wait-queue table. Commands enter on req_* (valid/ready); each yields one or
// more items on rsp_* (valid/ready), the final one with rsp_last set. The
// queue_enabled_mask register sits at byte address 0 of the APB port.
// Waiting threads live in a row of NUM_THREADS cells kept in age order,
// oldest in cell 0. Every cell compares its entry against the command at
// once; found, position and free-slot status ripple along the row, and a
// removed entry closes up as younger cells step down one place.
// Flow: a command is taken into the command registers while the sequencer
// is idle, and each item is registered in the output register by a step of
// the run state. A wake yields one item per thread that it frees (one item
// if it frees none); other commands yield one item. One command is in work
// at a time; req_ready is high while the sequencer is idle, also while the
// last item still waits in the output register.
// While an item waits in the output register with rsp_ready low, the
// sequencer holds and the cells do not change.
// Reset empties every cell and every queue and clears the enable mask.
module keyed_wait_queue_table_core
   import kwq_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [2:0]             req_cmd,
   input  logic [ThreadWidth-1:0] req_thread_id,
   input  logic [QueueWidth-1:0]  req_queue_id,
   input  logic [KeyWidth-1:0]    req_wait_key_in,
   input  logic                   req_sleep_interruptible,
   input  logic                   req_exit_requested,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [1:0]             rsp_status,
   output logic                   rsp_woken_valid,
   output logic [ThreadWidth-1:0] rsp_woken_thread,
   output logic [CountWidth-1:0]  rsp_woken_count,
   output logic                   rsp_last,
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [2:0]             paddr,
   input  logic [31:0]            pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);

   `include "assert_macros.svh"

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } state_type;

   state_type state_ff, state_in;

   logic [2:0]             cmd_ff;
   logic [ThreadWidth-1:0] thread_ff;
   logic [QueueWidth-1:0]  queue_ff;
   logic [KeyWidth-1:0]    key_ff;
   logic                   intr_ff, exit_ff;
   logic [CountWidth-1:0]  cnt_ff, cnt_in;
   logic [7:0]             mask_ff;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [1:0]             status_ff, status_in;
   logic                   wvalid_ff, wvalid_in;
   logic [ThreadWidth-1:0] wthread_ff, wthread_in;
   logic [CountWidth-1:0]  wcount_ff, wcount_in;
   logic                   last_ff, last_in;

   bcast_type              bcast;
   cell_data_type          cell_data [NUM_THREADS+1];
   chain_type              chain [NUM_THREADS+1];
   logic [NUM_THREADS-1:0] kill_vec, valid_vec;

   logic req_take, out_free, step, t_ok, q_ok, enabled, is_wake;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign step      = (state_ff == ST_RUN) && out_free;

   assign t_ok    = 32'(thread_ff) < NUM_THREADS;
   assign q_ok    = 32'(queue_ff) < NUM_QUEUES;
   assign enabled = q_ok && mask_ff[queue_ff];
   assign is_wake = (cmd_ff == CMD_WAKE_ONE) || (cmd_ff == CMD_WAKE_ALL)
                    || (cmd_ff == CMD_WAKE_KEY);

   // APB register
   assign pready = 1'b1;
   assign prdata = paddr[2] ? 32'd0 : {24'd0, mask_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else if (psel && penable && pwrite && !paddr[2]) begin
         mask_ff <= pwdata[7:0];
      end
   end

   // broadcast to cells
   always_comb begin
      bcast.by_thread = !is_wake;
      bcast.need_intr = (cmd_ff == CMD_INTERRUPT);
      bcast.keyed     = (cmd_ff == CMD_WAKE_KEY);
      bcast.thread    = thread_ff;
      bcast.queue     = queue_ff;
      bcast.key       = key_ff;
      bcast.intr      = intr_ff;
      bcast.kill_en   = step && ((is_wake && q_ok)
                        || (((cmd_ff == CMD_CANCEL) || (cmd_ff == CMD_INTERRUPT)) && t_ok));
      bcast.load_en   = step && (cmd_ff == CMD_SLEEP) && enabled && t_ok
                        && !chain[NUM_THREADS].found && !(intr_ff && exit_ff);
   end

   assign chain[0]               = '{shift: 1'b0, found: 1'b0, more: 1'b0,
                                     prev_valid: 1'b1, thread: '0};
   assign cell_data[NUM_THREADS] = '0;

   for (genvar i = 0; i < NUM_THREADS; i++) begin : g_cell
      kwq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .bcast      (bcast),
         .data_above (cell_data[i+1]),
         .data       (cell_data[i]),
         .chain_in   (chain[i]),
         .chain_out  (chain[i+1]),
         .kill       (kill_vec[i])
      );
      assign valid_vec[i] = cell_data[i].valid;
   end

   // result of the current step
   always_comb begin
      status_in  = STATUS_REFUSED;
      wvalid_in  = 1'b0;
      wthread_in = '0;
      wcount_in  = '0;
      last_in    = 1'b1;
      case (cmd_ff)
         CMD_SLEEP: begin
            if (!enabled || !t_ok || chain[NUM_THREADS].found) begin
               status_in = STATUS_REFUSED;
            end else if (intr_ff && exit_ff) begin
               status_in = STATUS_INTR;
            end else begin
               status_in = STATUS_DONE;
            end
         end
         CMD_WAKE_ONE, CMD_WAKE_ALL, CMD_WAKE_KEY: begin
            if (!q_ok || !chain[NUM_THREADS].found) begin
               status_in = STATUS_NONE;
            end else begin
               status_in  = STATUS_DONE;
               wvalid_in  = 1'b1;
               wthread_in = chain[NUM_THREADS].thread;
               wcount_in  = cnt_ff + CountWidth'(1);
               last_in    = (cmd_ff == CMD_WAKE_ONE) || !chain[NUM_THREADS].more;
            end
         end
         CMD_CANCEL: begin
            status_in = (t_ok && chain[NUM_THREADS].found) ? STATUS_DONE : STATUS_NONE;
         end
         CMD_INTERRUPT: begin
            if (t_ok && chain[NUM_THREADS].found) begin
               status_in  = STATUS_DONE;
               wvalid_in  = 1'b1;
               wthread_in = thread_ff;
               wcount_in  = CountWidth'(1);
            end else begin
               status_in = STATUS_NONE;
            end
         end
         default: begin
            status_in = STATUS_REFUSED;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_RUN;
               cnt_in   = '0;
            end
         end
         ST_RUN: begin
            if (step) begin
               rsp_valid_in = 1'b1;
               cnt_in       = wcount_in;
               if (last_in) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         cmd_ff    <= req_cmd;
         thread_ff <= req_thread_id;
         queue_ff  <= req_queue_id;
         key_ff    <= req_wait_key_in;
         intr_ff   <= req_sleep_interruptible;
         exit_ff   <= req_exit_requested;
      end
      if (step) begin
         status_ff  <= status_in;
         wvalid_ff  <= wvalid_in;
         wthread_ff <= wthread_in;
         wcount_ff  <= wcount_in;
         last_ff    <= last_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_woken_valid  = wvalid_ff;
   assign rsp_woken_thread = wthread_ff;
   assign rsp_woken_count  = wcount_ff;
   assign rsp_last         = last_ff;

   `KWQ_ASSERT(a_one_kill, $onehot0(kill_vec), "more than one cell removed in a cycle")
   `KWQ_ASSERT(a_packed, ((valid_vec + NUM_THREADS'(1)) & valid_vec) == '0, "gap among waiting cells")
   `KWQ_ASSERT(a_count, rsp_valid |-> (rsp_woken_valid == (rsp_woken_count != '0)), "woken count mismatch")
   `KWQ_ASSERT(a_more, (step && !last_in) |=> (state_ff == ST_RUN), "wake ended early")

endmodule

[design/kwq_cell.sv]
`timescale 1ns / 1ps
module kwq_cell
   import kwq_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  bcast_type     bcast,
   input  cell_data_type data_above,
   output cell_data_type data,
   input  chain_type     chain_in,
   output chain_type     chain_out,
   output logic          kill
);

   cell_data_type data_ff, data_in;
   logic          match, eff_valid, load;

   assign data = data_ff;

   always_comb begin
      if (bcast.by_thread) begin
         match = data_ff.valid && (data_ff.thread == bcast.thread)
                 && (!bcast.need_intr || data_ff.intr);
      end else begin
         match = data_ff.valid && (data_ff.queue == bcast.queue)
                 && (!bcast.keyed || (data_ff.key == bcast.key));
      end
   end

   // only the oldest match is removed
   assign kill      = match && !chain_in.found && bcast.kill_en;
   assign eff_valid = data_ff.valid && !kill;
   // appended item goes into the first free cell
   assign load      = bcast.load_en && !data_ff.valid && chain_in.prev_valid;

   always_comb begin
      chain_out.shift      = chain_in.shift || !eff_valid;
      chain_out.found      = chain_in.found || match;
      chain_out.more       = chain_in.more || (match && chain_in.found);
      chain_out.prev_valid = data_ff.valid;
      if (chain_in.found) begin
         chain_out.thread = chain_in.thread;
      end else if (match) begin
         chain_out.thread = data_ff.thread;
      end else begin
         chain_out.thread = '0;
      end
   end

   always_comb begin
      data_in = data_ff;
      if (load) begin
         data_in.valid  = 1'b1;
         data_in.thread = bcast.thread;
         data_in.queue  = bcast.queue;
         data_in.key    = bcast.key;
         data_in.intr   = bcast.intr;
      end else if (chain_out.shift) begin
         data_in = data_above;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff.valid <= 1'b0;
      end else begin
         data_ff.valid <= data_in.valid;
      end
      data_ff.thread <= data_in.thread;
      data_ff.queue  <= data_in.queue;
      data_ff.key    <= data_in.key;
      data_ff.intr   <= data_in.intr;
   end

endmodule
